### rtl/core/smmt_pkg.sv
// Shared types and constants for the sample min/max/mean tracker.
// No dependencies; used by smmt_ctrl, smmt_dp and the top level.
`timescale 1ns / 1ps

package smmt_pkg;

  localparam int CODE_BITS    = 10;
  localparam int CV_BITS      = 9;
  localparam int FLOOR_BITS   = 14;
  localparam int PROD_BITS    = 19;
  localparam int COUNT_BITS   = 32;
  localparam int SUM_BITS     = COUNT_BITS + CV_BITS;
  localparam int SAMPLES_BITS = 32;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 80;
  localparam int OUT_FIELDS_W = 3 * CV_BITS + FLOOR_BITS + SAMPLES_BITS;

  localparam int DIV_STEPS = CV_BITS;
  localparam int STEP_BITS = $clog2(DIV_STEPS);

  localparam logic [PROD_BITS-1:0]  FULL_SCALE = PROD_BITS'(500);
  localparam logic [10:0]           CODE_SPAN  = 11'd1023;
  localparam logic [FLOOR_BITS-1:0] FLOOR_NONE = FLOOR_BITS'(9999);

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef struct packed {
    logic load_in;
    logic scale;
    logic quot;
    logic update;
    logic div_load;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
  } dp_sts_t;

  typedef struct packed {
    logic [SAMPLES_BITS-1:0] samples_taken;
    logic [CV_BITS-1:0]      mean_centivolts;
    logic [FLOOR_BITS-1:0]   floor_centivolts;
    logic [CV_BITS-1:0]      peak_centivolts;
    logic [CV_BITS-1:0]      current_centivolts;
  } result_t;

endpackage

### rtl/core/smmt_ctrl.sv
// Sequencing state machine for the tracker: input beat, scale, update, divide, output.
// Depends on smmt_pkg; drives smmt_dp through dp_cmd_t.
`timescale 1ns / 1ps

module smmt_ctrl
  import smmt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_valid_i,
  output logic    s_ready_o,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MUL    = 7'b0000010,
    S_QUOT   = 7'b0000100,
    S_UPDATE = 7'b0001000,
    S_LOAD   = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e               state_q, state_d;
  logic [STEP_BITS-1:0] step_q, step_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  assign out_free  = !out_valid_q || m_ready_i;
  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.scale = 1'b1;
        state_d     = S_QUOT;
      end
      S_QUOT: begin
        cmd_o.quot = 1'b1;
        state_d    = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.div_load = 1'b1;
        step_d         = '0;
        state_d        = sts_i.count_zero ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + STEP_BITS'(1);
        if (step_q == STEP_BITS'(DIV_STEPS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> out_free)
    else $error("result register overwritten while still held");
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o) |=> (state_q == S_MUL))
    else $error("accepted beat did not start processing");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (step_q < STEP_BITS'(DIV_STEPS)))
    else $error("divide step counter overran");
`endif

endmodule

### rtl/core/smmt_dp.sv
// Datapath: scaling, statistic registers, bit-serial mean divider and result register.
// Depends on smmt_pkg; controlled by smmt_ctrl through dp_cmd_t.
`timescale 1ns / 1ps

module smmt_dp
  import smmt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  input  logic                 op_i,
  input  logic [CODE_BITS-1:0] code_i,
  output dp_sts_t              sts_o,
  output result_t              result_o
);

  logic                  op_q;
  logic [CODE_BITS-1:0]  code_q;
  logic [PROD_BITS-1:0]  prod_q;
  logic [CV_BITS-1:0]    cur_q;
  logic [CV_BITS-1:0]    peak_q;
  logic [FLOOR_BITS-1:0] floor_q;
  logic [SUM_BITS-1:0]   sum_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [SUM_BITS-1:0]   rem_q;
  logic [SUM_BITS-1:0]   dvs_q;
  logic [CV_BITS-1:0]    mean_q;
  result_t               result_q;

  logic [CV_BITS-1:0]    q0;
  logic [10:0]           r0;
  logic [CV_BITS-1:0]    cur_d;
  logic                  ge;
  logic                  count_full;

  // divide by 1023: remainder of x>>10 stays below twice the divisor
  assign q0    = prod_q[PROD_BITS-1:10];
  assign r0    = {1'b0, prod_q[9:0]} + 11'(q0);
  assign cur_d = (op_q == OP_CLEAR) ? '0 : q0 + CV_BITS'(r0 >= CODE_SPAN);

  assign ge         = (rem_q >= dvs_q);
  assign count_full = (count_q == {COUNT_BITS{1'b1}});

  assign sts_o.count_zero = (count_q == '0);
  assign result_o         = result_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q   <= op_i;
      code_q <= code_i;
    end
    if (cmd_i.scale) begin
      prod_q <= PROD_BITS'(code_q) * FULL_SCALE;
    end
    if (cmd_i.quot) begin
      cur_q <= cur_d;
    end
    if (cmd_i.div_load) begin
      rem_q  <= sum_q;
      dvs_q  <= SUM_BITS'({count_q, {(CV_BITS-1){1'b0}}});
      mean_q <= '0;
    end else if (cmd_i.div_step) begin
      if (ge) begin
        rem_q <= rem_q - dvs_q;
      end
      dvs_q  <= dvs_q >> 1;
      mean_q <= {mean_q[CV_BITS-2:0], ge};
    end
    if (cmd_i.out_load) begin
      result_q.current_centivolts <= cur_q;
      result_q.peak_centivolts    <= peak_q;
      result_q.floor_centivolts   <= floor_q;
      result_q.mean_centivolts    <= mean_q;
      result_q.samples_taken      <= SAMPLES_BITS'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q  <= '0;
      floor_q <= FLOOR_NONE;
      sum_q   <= '0;
      count_q <= '0;
    end else if (cmd_i.update) begin
      if (op_q == OP_CLEAR) begin
        peak_q  <= '0;
        floor_q <= FLOOR_NONE;
        sum_q   <= '0;
        count_q <= '0;
      end else begin
        if (!count_full) begin
          sum_q   <= sum_q + SUM_BITS'(cur_q);
          count_q <= count_q + COUNT_BITS'(1);
        end
        if (cur_q > peak_q) begin
          peak_q <= cur_q;
        end
        if (FLOOR_BITS'(cur_q) < floor_q) begin
          floor_q <= FLOOR_BITS'(cur_q);
        end
      end
    end
  end

`ifndef SYNTH
  a_empty_stats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (peak_q == '0 && floor_q == FLOOR_NONE && sum_q == '0))
    else $error("empty statistics not at cleared values");
  a_floor_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (FLOOR_BITS'(peak_q) >= floor_q))
    else $error("minimum above maximum");
  a_scale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.quot |=> (PROD_BITS'(cur_q) <= FULL_SCALE))
    else $error("scaled sample out of range");
`endif

endmodule

### rtl/core/sample_min_max_mean_tracker.sv
// Top level of the sample min/max/mean tracker: stream ports around smmt_ctrl and smmt_dp.
// Depends on smmt_pkg, smmt_ctrl and smmt_dp.
`timescale 1ns / 1ps

// Each input beat is a 10-bit converter code (tuser low) or a clear command (tuser high)
// and yields one output beat: the sample scaled to centivolts as floor(code*500/1023),
// the running peak and floor, the truncated mean and the saturating sample count. Each item
// goes through multiply, divide by 1023, statistics update, then a nine-step restoring
// divide for the mean; a clear skips the divide. A new beat is taken in the cycle after
// the previous result is handed to the output register, so the next item overlaps a result
// that is still waiting downstream.
module sample_min_max_mean_tracker
  import smmt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [9:0] adc_code
  input  logic                   s_axis_tuser,  // [0] operation
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [8:0] current_centivolts, [17:9] peak_centivolts, [31:18] floor_centivolts,
  // [40:32] mean_centivolts, [72:41] samples_taken
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  result_t result;

  smmt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  smmt_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .op_i     (s_axis_tuser),
    .code_i   (s_axis_tdata[CODE_BITS-1:0]),
    .sts_o    (sts),
    .result_o (result)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, result};

endmodule

### dv/testbench.sv
// Self-checking bench for sample_min_max_mean_tracker: predicts each result beat from the
// input beats and compares it field by field. Depends on smmt_pkg and the RTL top level.
`timescale 1ns / 1ps

module testbench;
  import smmt_pkg::*;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [9:0] adc_code
  logic                   s_axis_tuser = 1'b0; // [0] operation
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [8:0] current, [17:9] peak, [31:18] floor, [40:32] mean, [72:41] samples_taken
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  logic [CV_BITS-1:0]      peak_cv;
  logic [FLOOR_BITS-1:0]   floor_cv;
  logic [SUM_BITS-1:0]     sum_cv;
  logic [COUNT_BITS-1:0]   sample_count;
  result_t                 pending_results[$];
  int unsigned             mismatch_count = 0;
  bit                      idle_en = 1'b1;

  sample_min_max_mean_tracker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void clear_tracking();
    peak_cv      = '0;
    floor_cv     = FLOOR_NONE;
    sum_cv       = '0;
    sample_count = '0;
  endfunction

  // Updates the running statistics and returns the beat the block should produce.
  function automatic result_t track_sample(op_e op, logic [CODE_BITS-1:0] code);
    result_t             res;
    int unsigned         cur;
    logic [SUM_BITS-1:0] mean;
    cur = 0;
    if (op == OP_CLEAR) begin
      clear_tracking();
    end else begin
      cur = (int'(code) * 500) / 1023;
      if (sample_count != '1) begin
        sum_cv       = sum_cv + SUM_BITS'(cur);
        sample_count = sample_count + 1'b1;
      end
      if (cur > peak_cv) peak_cv = CV_BITS'(cur);
      if (cur < floor_cv) floor_cv = FLOOR_BITS'(cur);
    end
    mean = (sample_count != 0) ? sum_cv / SUM_BITS'(sample_count) : '0;
    res.current_centivolts = CV_BITS'(cur);
    res.peak_centivolts    = peak_cv;
    res.floor_centivolts   = floor_cv;
    res.mean_centivolts    = CV_BITS'(mean);
    res.samples_taken      = SAMPLES_BITS'(sample_count);
    return res;
  endfunction

  task automatic send_beat(input op_e op, input logic [CODE_BITS-1:0] code);
    int gap;
    gap = 0;
    if (idle_en) while ($urandom_range(99) < 35) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(code);
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(track_sample(op, code));
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= !idle_en || ($urandom_range(99) >= 35);
  end

  function automatic void compare_field(string name, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      $display("%0t %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_result
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[OUT_FIELDS_W-1:0]);
      if (pending_results.size() == 0) begin
        $display("%0t unexpected beat expected none actual %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("current_centivolts", want.current_centivolts, got.current_centivolts);
        compare_field("peak_centivolts", want.peak_centivolts, got.peak_centivolts);
        compare_field("floor_centivolts", want.floor_centivolts, got.floor_centivolts);
        compare_field("mean_centivolts", want.mean_centivolts, got.mean_centivolts);
        compare_field("samples_taken", want.samples_taken, got.samples_taken);
      end
    end
  end

  // Codes 0 and 1023, neighbours of both ends and the mid-scale step.
  task automatic test_extremes();
    send_beat(OP_SAMPLE, 10'd1023);
    send_beat(OP_SAMPLE, 10'd0);
    send_beat(OP_CLEAR,  10'd1023);
    send_beat(OP_SAMPLE, 10'd0);
    send_beat(OP_SAMPLE, 10'd1023);
    send_beat(OP_SAMPLE, 10'd1);
    send_beat(OP_SAMPLE, 10'd1022);
    send_beat(OP_SAMPLE, 10'd2);
    send_beat(OP_SAMPLE, 10'd3);
    send_beat(OP_SAMPLE, 10'd511);
    send_beat(OP_SAMPLE, 10'd512);
    send_beat(OP_SAMPLE, 10'd1021);
  endtask

  // Clear with junk code, back-to-back clears, first sample after clear.
  task automatic test_clear();
    send_beat(OP_CLEAR,  10'h2AA);
    send_beat(OP_SAMPLE, 10'd512);
    send_beat(OP_CLEAR,  10'h155);
    send_beat(OP_CLEAR,  10'h3FF);
    send_beat(OP_SAMPLE, 10'd1023);
    send_beat(OP_SAMPLE, 10'd0);
    send_beat(OP_CLEAR,  10'd0);
    send_beat(OP_SAMPLE, 10'd0);
    send_beat(OP_SAMPLE, 10'd700);
  endtask

  task automatic random_items(input int n);
    int centre;
    int code;
    centre = $urandom_range(1023);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 3) begin
        send_beat(OP_CLEAR, 10'($urandom_range(1023)));
        centre = $urandom_range(1023);
      end else begin
        case ($urandom_range(9))
          0, 1: code = $urandom_range(1) ? 1023 - $urandom_range(2) : $urandom_range(2);
          2, 3, 4: begin
            code = centre + $urandom_range(40) - 20;
            if (code < 0) code = 0;
            if (code > 1023) code = 1023;
          end
          default: code = $urandom_range(1023);
        endcase
        send_beat(OP_SAMPLE, 10'(code));
      end
    end
  endtask

  task automatic test_random_stream();
    idle_en = 1'b1;
    random_items(700);
  endtask

  task automatic test_unbroken_stream();
    idle_en = 1'b0;
    random_items(150);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    idle_en = 1'b1;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    clear_tracking();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_extremes();
    test_clear();
    test_random_stream();
    test_unbroken_stream();
    drain_results();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sample_min_max_mean_tracker.f
rtl/core/smmt_pkg.sv
rtl/core/smmt_ctrl.sv
rtl/core/smmt_dp.sv
rtl/core/sample_min_max_mean_tracker.sv
dv/testbench.sv
